// ===== rtl/tga_image_stream_decoder_assert.svh =====
// Assertion macros shared by the checker of the TGA stream decoder.
`ifndef TGA_IMAGE_STREAM_DECODER_ASSERT_SVH
`define TGA_IMAGE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TGA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tga decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TGA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tga decoder: next-cycle check failed");

`endif

// ===== rtl/tga_pkg.sv =====
package tga_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} tga_in_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_count;
		logic        image_done;
		logic        status;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} tga_out_t;

	// Result handed from the decoder core to the output buffer.
	typedef struct packed {
		logic     valid;
		tga_out_t item;
	} tga_res_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_PACKET,
		PH_PIXEL
	} tga_phase_t;

	localparam logic [7:0] TYPE_PACKED   = 8'h0A;
	localparam logic [7:0] TYPE_UNPACKED = 8'h02;
	localparam logic [7:0] DEPTH_ALPHA   = 8'd32;
	localparam logic [7:0] OPAQUE        = 8'd255;

	localparam logic [4:0] HDR_ID_LEN  = 5'd0;
	localparam logic [4:0] HDR_TYPE    = 5'd2;
	localparam logic [4:0] HDR_WIDTH_L = 5'd12;
	localparam logic [4:0] HDR_WIDTH_H = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_L = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_H = 5'd15;
	localparam logic [4:0] HDR_DEPTH   = 5'd16;
	localparam logic [4:0] HDR_LAST    = 5'd17;

	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;
	localparam logic [1:0] CH_ALPHA = 2'd3;

endpackage

// ===== rtl/tga_image_stream_decoder.sv =====
// TGA image stream decoder.
// The input channel (in_valid, in_ready, in_data) carries the file one byte per
// transfer; start_of_file marks byte 0 of the header and abandons any file in
// progress. The output channel (out_valid, out_ready, out_data) carries one
// result per finished pixel: a colour with its repeat count, or a single
// status result for an unsupported image type.
// Every byte is decoded combinationally by the parser core, so one byte is
// taken per clock cycle while in_ready is high. A result is registered in the
// output register, or in the skid entry while the receiver stalls the output.
// The output side has an output register and one skid entry. While the
// receiver stalls the decoder keeps taking bytes until the skid entry holds a
// result; in_ready then drops, and rises again in the cycle after the result
// in the output register is transferred and the skid entry moves into it.
// After reset the decoder is idle and ignores bytes until a start mark.
// The pixel count of an image is the product of width and height, formed by
// one 16 by 16 multiplier when the last header byte is taken.
module tga_image_stream_decoder import tga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  tga_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output tga_out_t out_data
);

	logic     accept;
	tga_res_t res;

	assign accept = in_valid && in_ready;

	tga_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_item (in_data),
		.res     (res)
	);

	tga_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_res  (res),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/tga_parse.sv =====
module tga_parse import tga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  tga_in_t  in_item,
	output tga_res_t res
);

	tga_phase_t  phase_q, phase_d, cur_phase;
	logic [4:0]  hidx_q, hidx_d;
	logic [7:0]  id_left_q, id_left_d;
	logic [7:0]  itype_q, itype_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  bpp_q, bpp_d;
	logic [31:0] pix_left_q, pix_left_d;
	logic        is_run_q, is_run_d;
	logic [7:0]  pkt_left_q, pkt_left_d;
	logic [1:0]  ch_q, ch_d;
	logic [23:0] colour_q, colour_d;

	logic [7:0]  b;
	logic        packed_img;
	logic        last_ch;
	logic [7:0]  cnt;
	tga_phase_t  data_ph;

	assign b = in_item.data_byte;

	always_comb begin
		phase_d    = phase_q;
		hidx_d     = hidx_q;
		id_left_d  = id_left_q;
		itype_d    = itype_q;
		width_d    = width_q;
		height_d   = height_q;
		bpp_d      = bpp_q;
		pix_left_d = pix_left_q;
		is_run_d   = is_run_q;
		pkt_left_d = pkt_left_q;
		ch_d       = ch_q;
		colour_d   = colour_q;
		cur_phase  = phase_q;
		last_ch    = 1'b0;
		cnt        = 8'd0;
		res        = '0;

		// A start mark abandons any file in progress and restarts the header.
		if (in_item.start_of_file) begin
			cur_phase  = PH_HEADER;
			hidx_d     = 5'd0;
			id_left_d  = 8'd0;
			itype_d    = 8'd0;
			width_d    = 16'd0;
			height_d   = 16'd0;
			bpp_d      = 8'd0;
			pix_left_d = 32'd0;
			is_run_d   = 1'b0;
			pkt_left_d = 8'd0;
			ch_d       = 2'd0;
			colour_d   = 24'd0;
		end
		phase_d    = cur_phase;
		packed_img = (itype_d == TYPE_PACKED);
		data_ph    = packed_img ? PH_PACKET : PH_PIXEL;

		case (cur_phase)
			PH_HEADER: begin
				case (hidx_d)
					HDR_ID_LEN:   id_left_d = b;
					HDR_TYPE:     itype_d = b;
					HDR_WIDTH_L:  width_d[7:0] = b;
					HDR_WIDTH_H:  width_d[15:8] = b;
					HDR_HEIGHT_L: height_d[7:0] = b;
					HDR_HEIGHT_H: height_d[15:8] = b;
					HDR_DEPTH:    bpp_d = b;
					default: ;
				endcase
				if (hidx_d < HDR_LAST) begin
					hidx_d = hidx_d + 5'd1;
				end else if (itype_d != TYPE_PACKED && itype_d != TYPE_UNPACKED) begin
					phase_d                = PH_IDLE;
					res.valid              = 1'b1;
					res.item.status        = 1'b1;
					res.item.image_width   = width_d;
					res.item.image_height  = height_d;
				end else begin
					pix_left_d = 32'(width_d) * 32'(height_d);
					ch_d       = 2'd0;
					pkt_left_d = 8'd0;
					if (width_d == 16'd0 || height_d == 16'd0) begin
						phase_d = PH_IDLE;
					end else if (id_left_d != 8'd0) begin
						phase_d = PH_SKIP;
					end else begin
						phase_d = data_ph;
					end
				end
			end
			PH_SKIP: begin
				id_left_d = id_left_d - 8'd1;
				if (id_left_d == 8'd0) begin
					phase_d = data_ph;
				end
			end
			PH_PACKET: begin
				is_run_d   = b[7];
				pkt_left_d = {1'b0, b[6:0]} + 8'd1;
				ch_d       = 2'd0;
				phase_d    = PH_PIXEL;
			end
			PH_PIXEL: begin
				case (ch_d)
					CH_BLUE:  colour_d[7:0] = b;
					CH_GREEN: colour_d[15:8] = b;
					CH_RED:   colour_d[23:16] = b;
					default: ;
				endcase
				last_ch = (bpp_d == DEPTH_ALPHA) ? (ch_d == CH_ALPHA) : (ch_d == CH_RED);
				if (!last_ch) begin
					ch_d = ch_d + 2'd1;
				end else begin
					ch_d = 2'd0;
					if (packed_img && is_run_d) begin
						cnt = ({24'd0, pkt_left_d} > pix_left_d) ? pix_left_d[7:0] : pkt_left_d;
						pkt_left_d = 8'd0;
					end else begin
						cnt = 8'd1;
						if (packed_img && pkt_left_d != 8'd0) begin
							pkt_left_d = pkt_left_d - 8'd1;
						end
					end
					pix_left_d = pix_left_d - {24'd0, cnt};
					if (pix_left_d == 32'd0) begin
						phase_d = PH_IDLE;
					end else if (packed_img && pkt_left_d == 8'd0) begin
						phase_d = PH_PACKET;
					end
					res.valid             = 1'b1;
					res.item.red          = colour_d[23:16];
					res.item.green        = colour_d[15:8];
					res.item.blue         = colour_d[7:0];
					res.item.alpha        = (bpp_d == DEPTH_ALPHA) ? b : OPAQUE;
					res.item.repeat_count = cnt;
					res.item.image_done   = (pix_left_d == 32'd0);
					res.item.status       = 1'b0;
					res.item.image_width  = width_d;
					res.item.image_height = height_d;
				end
			end
			default: ;
		endcase

		if (!accept) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hidx_q     <= 5'd0;
			id_left_q  <= 8'd0;
			itype_q    <= 8'd0;
			width_q    <= 16'd0;
			height_q   <= 16'd0;
			bpp_q      <= 8'd0;
			pix_left_q <= 32'd0;
			is_run_q   <= 1'b0;
			pkt_left_q <= 8'd0;
			ch_q       <= 2'd0;
			colour_q   <= 24'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			hidx_q     <= hidx_d;
			id_left_q  <= id_left_d;
			itype_q    <= itype_d;
			width_q    <= width_d;
			height_q   <= height_d;
			bpp_q      <= bpp_d;
			pix_left_q <= pix_left_d;
			is_run_q   <= is_run_d;
			pkt_left_q <= pkt_left_d;
			ch_q       <= ch_d;
			colour_q   <= colour_d;
		end
	end

endmodule

// ===== rtl/tga_outbuf.sv =====
module tga_outbuf import tga_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tga_res_t push_res,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output tga_out_t out_data
);

	logic     out_valid_q;
	tga_out_t out_data_q;
	logic     skid_valid_q;
	tga_out_t skid_data_q;
	logic     free;

	// The skid entry catches a result while the output register is stalled.
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign free      = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q  <= skid_valid_q || push_res.valid;
			skid_valid_q <= skid_valid_q && push_res.valid;
		end else if (push_res.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			out_data_q  <= skid_valid_q ? skid_data_q : push_res.item;
			skid_data_q <= push_res.item;
		end else if (push_res.valid) begin
			skid_data_q <= push_res.item;
		end
	end

endmodule

// ===== rtl/tga_checker.sv =====
`include "tga_image_stream_decoder_assert.svh"

module tga_checker import tga_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input tga_out_t out_data
);

	`TGA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`TGA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
	// Input stalls only when a result is already waiting at the output.
	`TGA_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid)
	`TGA_ASSERT_NOW(a_status_fields, out_valid && out_data.status, out_data.repeat_count == 8'd0 && !out_data.image_done)
	`TGA_ASSERT_NOW(a_pixel_count, out_valid && !out_data.status, out_data.repeat_count != 8'd0 && out_data.repeat_count <= 8'd128)

endmodule

bind tga_image_stream_decoder tga_checker u_tga_checker (.*);
